/* design/pcbpa_pkg.sv */
// Shared types, field widths and codes for the per-CPU block pool allocator.
package pcbpa_pkg;

    localparam int NUM_CPUS_DEF = 8;
    localparam int BLOCKS_PER_POOL_DEF = 64;

    // Request fields.
    localparam int FUNC_W  = 2;
    localparam int CPU_F_W = 3;
    localparam int BYTES_W = 16;
    localparam int HBLK_W  = 6;

    // Response fields.
    localparam int STATUS_W = 3;
    localparam int PCNT_W   = 7;
    localparam int TOT_W    = 32;
    localparam int SYSO_W   = 10;

    localparam int S_FIELDS_W = CPU_F_W + BYTES_W + CPU_F_W + HBLK_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_PAD_W    = S_TDATA_W - S_FIELDS_W;

    localparam int M_FIELDS_W = CPU_F_W + HBLK_W + 2 * PCNT_W + 4 * TOT_W + SYSO_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [BYTES_W-1:0] MAX_BYTES_RST = BYTES_W'(256);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_STATS = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_REQ     = 3'd1,
        ST_NO_BLOCK    = 3'd2,
        ST_NOT_LOCAL   = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } status_t;

    // Per-pool update commands for one processed request.
    typedef struct packed {
        logic take;        // mark the pool's lowest free block busy
        logic put_back;    // mark the addressed block free
        logic cnt_alloc;
        logic cnt_free;
        logic cnt_borrow;
        logic cnt_lend;
    } lane_op_t;

endpackage

/* design/pcbpa_lane.sv */
// One pool: busy map, occupancy and event counters, lowest-free-block finder.
module pcbpa_lane #(
    parameter int BLOCKS_PER_POOL = pcbpa_pkg::BLOCKS_PER_POOL_DEF,
    parameter int IDX_W = $clog2(BLOCKS_PER_POOL),
    parameter int CNT_W = $clog2(BLOCKS_PER_POOL + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pcbpa_pkg::lane_op_t     op,
    input  logic [IDX_W-1:0]        rel_idx,
    output logic                    has_free,
    output logic [IDX_W-1:0]        low_idx,
    output logic [CNT_W-1:0]        free_cnt,
    output logic                    busy_at,
    output logic [CNT_W-1:0]        free_cnt_nx,
    output logic [CNT_W-1:0]        used_cnt_nx,
    output logic [pcbpa_pkg::TOT_W-1:0] alloc_nx,
    output logic [pcbpa_pkg::TOT_W-1:0] freeev_nx,
    output logic [pcbpa_pkg::TOT_W-1:0] borrow_nx,
    output logic [pcbpa_pkg::TOT_W-1:0] lend_nx
);
    import pcbpa_pkg::*;

    logic [BLOCKS_PER_POOL-1:0] busy_reg;
    logic [BLOCKS_PER_POOL-1:0] busy_next;
    logic [CNT_W-1:0]           free_cnt_reg;
    logic [CNT_W-1:0]           used_cnt_reg;
    logic [TOT_W-1:0]           alloc_reg;
    logic [TOT_W-1:0]           freeev_reg;
    logic [TOT_W-1:0]           borrow_reg;
    logic [TOT_W-1:0]           lend_reg;
    logic [BLOCKS_PER_POOL-1:0] free_vec;
    logic [BLOCKS_PER_POOL-1:0] low_bit;

    // Isolate the lowest free block, then encode the one-hot position.
    assign free_vec = ~busy_reg;
    assign low_bit  = free_vec & (~free_vec + BLOCKS_PER_POOL'(1));
    assign has_free = |free_vec;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < BLOCKS_PER_POOL; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign busy_at  = busy_reg[rel_idx];
    assign free_cnt = free_cnt_reg;

    always_comb begin
        busy_next = busy_reg;
        if (op.take) begin
            busy_next[low_idx] = 1'b1;
        end
        if (op.put_back) begin
            busy_next[rel_idx] = 1'b0;
        end
    end

    always_comb begin
        free_cnt_nx = free_cnt_reg;
        used_cnt_nx = used_cnt_reg;
        if (op.take) begin
            free_cnt_nx = free_cnt_reg - CNT_W'(1);
            used_cnt_nx = used_cnt_reg + CNT_W'(1);
        end else if (op.put_back) begin
            free_cnt_nx = free_cnt_reg + CNT_W'(1);
            used_cnt_nx = used_cnt_reg - CNT_W'(1);
        end
        alloc_nx  = alloc_reg  + TOT_W'(op.cnt_alloc);
        freeev_nx = freeev_reg + TOT_W'(op.cnt_free);
        borrow_nx = borrow_reg + TOT_W'(op.cnt_borrow);
        lend_nx   = lend_reg   + TOT_W'(op.cnt_lend);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= '0;
            free_cnt_reg <= CNT_W'(BLOCKS_PER_POOL);
            used_cnt_reg <= '0;
            alloc_reg    <= '0;
            freeev_reg   <= '0;
            borrow_reg   <= '0;
            lend_reg     <= '0;
        end else begin
            busy_reg     <= busy_next;
            free_cnt_reg <= free_cnt_nx;
            used_cnt_reg <= used_cnt_nx;
            alloc_reg    <= alloc_nx;
            freeev_reg   <= freeev_nx;
            borrow_reg   <= borrow_nx;
            lend_reg     <= lend_nx;
        end
    end

    // Free and used counts always account for the whole pool.
    a_cnt_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CNT_W + 1)'(free_cnt_reg) + (CNT_W + 1)'(used_cnt_reg))
            == (CNT_W + 1)'(BLOCKS_PER_POOL))
        else $error("pool free plus used count differs from pool size");

endmodule

/* design/pcbpa_steal_sel.sv */
// Picks the other pool with strictly the most free blocks, lowest index on a tie.
module pcbpa_steal_sel #(
    parameter int NUM_CPUS = pcbpa_pkg::NUM_CPUS_DEF,
    parameter int CNT_W    = $clog2(pcbpa_pkg::BLOCKS_PER_POOL_DEF + 1),
    parameter int CPU_W    = $clog2(NUM_CPUS)
) (
    input  logic [CNT_W-1:0] free_cnt [NUM_CPUS],
    input  logic [CPU_W-1:0] excl_idx,
    output logic [CPU_W-1:0] best_idx,
    output logic             found
);
    localparam int LEAVES = 2 ** $clog2(NUM_CPUS);
    localparam int NODES  = 2 * LEAVES - 1;

    logic [CNT_W-1:0] node_cnt [NODES];
    logic [CPU_W-1:0] node_idx [NODES];

    // Heap-ordered comparison tree; the left child holds the lower pool index,
    // so it wins unless the right child is strictly larger.
    always_comb begin
        for (int k = 0; k < LEAVES; k++) begin
            node_idx[LEAVES - 1 + k] = CPU_W'(k);
            if (k < NUM_CPUS && CPU_W'(k) != excl_idx) begin
                node_cnt[LEAVES - 1 + k] = free_cnt[k];
            end else begin
                node_cnt[LEAVES - 1 + k] = '0;
            end
        end
        for (int n = LEAVES - 2; n >= 0; n--) begin
            if (node_cnt[2 * n + 2] > node_cnt[2 * n + 1]) begin
                node_cnt[n] = node_cnt[2 * n + 2];
                node_idx[n] = node_idx[2 * n + 2];
            end else begin
                node_cnt[n] = node_cnt[2 * n + 1];
                node_idx[n] = node_idx[2 * n + 1];
            end
        end
    end

    assign best_idx = node_idx[0];
    assign found    = (node_cnt[0] != '0);

endmodule

/* design/per_cpu_block_pool_allocator_core.sv */
// Top level of the per-CPU fixed block pool allocator with stealing.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    tuser: func; tdata: cpu, bytes, pool, block
//  m_        out        m_tvalid/m_tready    tuser: status; tdata: grant and statistics
//  cfg_      in         cfg_valid/cfg_ready  cfg_data: max_request_bytes
//
// A request is captured in an input register and processed in the following cycle,
// when the result register is empty or being drained; the pool state and the result
// register update at that same edge. One request per cycle is sustained while results are
// taken, and each result is presented from the result register after its processing edge.
// The processing cycle holds the find-first-free over one pool's busy map, the free-count
// comparison tree across pools and the second find-first-free in the chosen pool. A
// stalled result holds the input register, and s_tready drops only when both registers
// are full and the result is not being taken. Reset (aresetn low, synchronous) frees
// every block, clears all counters and sets max_request_bytes to 256.
module per_cpu_block_pool_allocator_core #(
    parameter int NUM_CPUS        = pcbpa_pkg::NUM_CPUS_DEF,
    parameter int BLOCKS_PER_POOL = pcbpa_pkg::BLOCKS_PER_POOL_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Request channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] func
    input  logic [pcbpa_pkg::FUNC_W-1:0]       s_tuser,
    // [2:0] requester_cpu, [18:3] request_bytes, [21:19] handle_pool,
    // [27:22] handle_block, [31:28] zero
    input  logic [pcbpa_pkg::S_TDATA_W-1:0]    s_tdata,
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] status
    output logic [pcbpa_pkg::STATUS_W-1:0]     m_tuser,
    // [2:0] granted_pool, [8:3] granted_block, [15:9] pool_free_blocks,
    // [22:16] pool_used_blocks, [54:23] pool_alloc_total, [86:55] pool_free_total,
    // [118:87] pool_borrow_total, [150:119] pool_lend_total,
    // [160:151] system_free_blocks, [167:161] zero
    output logic [pcbpa_pkg::M_TDATA_W-1:0]    m_tdata,
    // Configuration write channel: max_request_bytes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pcbpa_pkg::BYTES_W-1:0]      cfg_data
);
    import pcbpa_pkg::*;

    localparam int CPU_W  = $clog2(NUM_CPUS);
    localparam int IDX_W  = $clog2(BLOCKS_PER_POOL);
    localparam int CNT_W  = $clog2(BLOCKS_PER_POOL + 1);
    localparam int TOTAL  = NUM_CPUS * BLOCKS_PER_POOL;
    localparam int SYSC_W = $clog2(TOTAL + 1);

    // Input register.
    logic                 in_vld_reg;
    logic [FUNC_W-1:0]    func_reg;
    logic [CPU_F_W-1:0]   cpu_reg;
    logic [BYTES_W-1:0]   bytes_reg;
    logic [CPU_F_W-1:0]   hpool_reg;
    logic [HBLK_W-1:0]    hblk_reg;

    logic [BYTES_W-1:0]   max_bytes_reg;
    logic [SYSC_W-1:0]    sys_free_reg;
    logic [SYSC_W-1:0]    sys_free_next;

    // Result register.
    logic                 m_vld_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    logic proc;
    logic s_accept;

    // Per-pool views.
    lane_op_t         lane_op   [NUM_CPUS];
    logic             has_free  [NUM_CPUS];
    logic [IDX_W-1:0] low_idx   [NUM_CPUS];
    logic [CNT_W-1:0] free_cnt  [NUM_CPUS];
    logic             busy_at   [NUM_CPUS];
    logic [CNT_W-1:0] free_nx   [NUM_CPUS];
    logic [CNT_W-1:0] used_nx   [NUM_CPUS];
    logic [TOT_W-1:0] alloc_nx  [NUM_CPUS];
    logic [TOT_W-1:0] freeev_nx [NUM_CPUS];
    logic [TOT_W-1:0] borrow_nx [NUM_CPUS];
    logic [TOT_W-1:0] lend_nx   [NUM_CPUS];
    logic [NUM_CPUS-1:0] take_vec;

    // Request decode.
    logic [CPU_W-1:0]  cpu_idx;
    logic [IDX_W-1:0]  rel_idx;
    logic              cpu_ok;
    logic              size_ok;
    logic              hblk_ok;
    logic [CPU_W-1:0]  steal_idx;
    logic              steal_found;

    status_t              status_c;
    logic                 do_local;
    logic                 do_steal;
    logic                 do_put_back;
    logic [CPU_F_W-1:0]   gpool_c;
    logic [HBLK_W-1:0]    gblock_c;
    logic [M_TDATA_W-1:0] m_tdata_c;

    // The processing stage fires whenever a request waits and the result slot is free.
    assign proc     = in_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_vld_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign cpu_idx = CPU_W'(cpu_reg);
    assign rel_idx = IDX_W'(hblk_reg);
    assign cpu_ok  = (32'(cpu_reg) < NUM_CPUS);
    assign size_ok = (bytes_reg != '0) && (bytes_reg <= max_bytes_reg);
    assign hblk_ok = (32'(hblk_reg) < BLOCKS_PER_POOL);

    for (genvar g = 0; g < NUM_CPUS; g++) begin : g_lane
        pcbpa_lane #(
            .BLOCKS_PER_POOL (BLOCKS_PER_POOL),
            .IDX_W           (IDX_W),
            .CNT_W           (CNT_W)
        ) u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (lane_op[g]),
            .rel_idx     (rel_idx),
            .has_free    (has_free[g]),
            .low_idx     (low_idx[g]),
            .free_cnt    (free_cnt[g]),
            .busy_at     (busy_at[g]),
            .free_cnt_nx (free_nx[g]),
            .used_cnt_nx (used_nx[g]),
            .alloc_nx    (alloc_nx[g]),
            .freeev_nx   (freeev_nx[g]),
            .borrow_nx   (borrow_nx[g]),
            .lend_nx     (lend_nx[g])
        );
    end

    pcbpa_steal_sel #(
        .NUM_CPUS (NUM_CPUS),
        .CNT_W    (CNT_W),
        .CPU_W    (CPU_W)
    ) u_steal_sel (
        .free_cnt (free_cnt),
        .excl_idx (cpu_idx),
        .best_idx (steal_idx),
        .found    (steal_found)
    );

    // Decide what the current request does. Every error leaves the pools untouched.
    always_comb begin
        status_c    = ST_OK;
        do_local    = 1'b0;
        do_steal    = 1'b0;
        do_put_back = 1'b0;
        gpool_c     = '0;
        gblock_c    = '0;
        if (!cpu_ok) begin
            status_c = ST_BAD_REQ;
        end else begin
            unique case (func_t'(func_reg))
                FUNC_ALLOC: begin
                    if (!size_ok) begin
                        status_c = ST_BAD_REQ;
                    end else if (has_free[cpu_idx]) begin
                        do_local = 1'b1;
                        gpool_c  = cpu_reg;
                        gblock_c = HBLK_W'(low_idx[cpu_idx]);
                    end else if (steal_found) begin
                        // Local pool is full: borrow from the other pool with the most free blocks.
                        do_steal = 1'b1;
                        gpool_c  = CPU_F_W'(steal_idx);
                        gblock_c = HBLK_W'(low_idx[steal_idx]);
                    end else begin
                        status_c = ST_NO_BLOCK;
                    end
                end
                FUNC_FREE: begin
                    if (!size_ok || !hblk_ok) begin
                        status_c = ST_BAD_REQ;
                    end else if (hpool_reg != cpu_reg) begin
                        status_c = ST_NOT_LOCAL;
                    end else if (!busy_at[cpu_idx]) begin
                        status_c = ST_DOUBLE_FREE;
                    end else begin
                        do_put_back = 1'b1;
                    end
                end
                FUNC_STATS: begin
                    status_c = ST_OK;
                end
                default: begin
                    status_c = ST_BAD_REQ;
                end
            endcase
        end
    end

    // Fan the decision out to the pools; nothing changes unless the stage fires.
    always_comb begin
        for (int i = 0; i < NUM_CPUS; i++) begin
            lane_op[i]            = '0;
            lane_op[i].take       = proc && ((do_local && CPU_W'(i) == cpu_idx)
                                          || (do_steal && CPU_W'(i) == steal_idx));
            lane_op[i].put_back   = proc && do_put_back && CPU_W'(i) == cpu_idx;
            lane_op[i].cnt_alloc  = proc && do_local && CPU_W'(i) == cpu_idx;
            lane_op[i].cnt_free   = proc && do_put_back && CPU_W'(i) == cpu_idx;
            lane_op[i].cnt_borrow = proc && do_steal && CPU_W'(i) == cpu_idx;
            lane_op[i].cnt_lend   = proc && do_steal && CPU_W'(i) == steal_idx;
            take_vec[i]           = lane_op[i].take;
        end
    end

    always_comb begin
        sys_free_next = sys_free_reg;
        if (proc && (do_local || do_steal)) begin
            sys_free_next = sys_free_reg - SYSC_W'(1);
        end else if (proc && do_put_back) begin
            sys_free_next = sys_free_reg + SYSC_W'(1);
        end
    end

    // Pack the response from the post-update counter values of the requester pool.
    always_comb begin
        if (cpu_ok) begin
            m_tdata_c = {M_PAD_W'(0), SYSO_W'(sys_free_next),
                         lend_nx[cpu_idx], borrow_nx[cpu_idx],
                         freeev_nx[cpu_idx], alloc_nx[cpu_idx],
                         PCNT_W'(used_nx[cpu_idx]), PCNT_W'(free_nx[cpu_idx]),
                         gblock_c, gpool_c};
        end else begin
            m_tdata_c = {M_PAD_W'(0), SYSO_W'(sys_free_next),
                         (4 * TOT_W + 2 * PCNT_W)'(0), gblock_c, gpool_c};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            m_vld_reg     <= 1'b0;
            max_bytes_reg <= MAX_BYTES_RST;
            sys_free_reg  <= SYSC_W'(TOTAL);
        end else begin
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (proc) begin
                in_vld_reg <= 1'b0;
            end
            if (proc) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
            if (cfg_valid) begin
                max_bytes_reg <= cfg_data;
            end
            sys_free_reg <= sys_free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg  <= s_tuser;
            cpu_reg   <= s_tdata[CPU_F_W-1:0];
            bytes_reg <= s_tdata[CPU_F_W +: BYTES_W];
            hpool_reg <= s_tdata[CPU_F_W + BYTES_W +: CPU_F_W];
            hblk_reg  <= s_tdata[2 * CPU_F_W + BYTES_W +: HBLK_W];
        end
        if (proc) begin
            m_tdata_reg <= m_tdata_c;
            m_tuser_reg <= status_c;
        end
    end

    // The system free count can never exceed the total number of blocks.
    a_sys_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sys_free_reg <= SYSC_W'(TOTAL))
        else $error("system free count above total block count");

    // Running out of blocks is only reported when no pool has a free block.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && status_c == ST_NO_BLOCK) |-> (sys_free_reg == '0))
        else $error("no-block status while free blocks remain");

    // A request takes at most one block from at most one pool.
    a_one_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(take_vec))
        else $error("more than one pool takes a block");

    // A rejected request leaves the system free count unchanged.
    a_err_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && status_c != ST_OK) |=> (sys_free_reg == $past(sys_free_reg)))
        else $error("failed request changed the system free count");

endmodule

/* dv/per_cpu_block_pool_allocator_core_test.sv */
// Self-checking testbench for the per-CPU block pool allocator core.
module per_cpu_block_pool_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pcbpa_pkg::*;

    localparam int NCPU = NUM_CPUS_DEF;
    localparam int NBLK = BLOCKS_PER_POOL_DEF;
    // The function field is two bits wide, so code 3 can be driven even though the
    // package has no name for it. The block must reject it as a bad request.
    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
    localparam int PHASE_ITEMS = 360;
    localparam int CYCLE_LIMIT = 400000;

    // Request payload as it sits on s_tdata, lowest field last in the declaration.
    typedef struct packed {
        logic [S_PAD_W-1:0]  pad;
        logic [HBLK_W-1:0]   hblock;
        logic [CPU_F_W-1:0]  hpool;
        logic [BYTES_W-1:0]  bytes;
        logic [CPU_F_W-1:0]  cpu;
    } req_word_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        req_word_t         word;
    } pool_req_t;

    // Result payload as it sits on m_tdata.
    typedef struct packed {
        logic [M_PAD_W-1:0]  pad;
        logic [SYSO_W-1:0]   sys_free;
        logic [TOT_W-1:0]    lend_total;
        logic [TOT_W-1:0]    borrow_total;
        logic [TOT_W-1:0]    free_total;
        logic [TOT_W-1:0]    alloc_total;
        logic [PCNT_W-1:0]   pool_used;
        logic [PCNT_W-1:0]   pool_free;
        logic [HBLK_W-1:0]   gblock;
        logic [CPU_F_W-1:0]  gpool;
    } stats_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        stats_word_t         word;
    } pool_reply_t;

    // One line of the directed stimulus: either a size limit write or a request,
    // with the reply typed in by hand where it is obvious.
    typedef struct {
        bit                 is_cfg;
        logic [BYTES_W-1:0] cfg_value;
        pool_req_t          req;
        bit                 typed;
        pool_reply_t        reply;
    } stim_row_t;

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [FUNC_W-1:0]    s_tuser   = '0;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [STATUS_W-1:0]  m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [BYTES_W-1:0]   cfg_data  = '0;

    // Shadow copy of the allocator state, kept by the predictor.
    logic [NBLK-1:0]    busy_map   [NCPU];
    logic [PCNT_W-1:0]  free_cnt   [NCPU];
    logic [PCNT_W-1:0]  used_cnt   [NCPU];
    logic [TOT_W-1:0]   alloc_tot  [NCPU];
    logic [TOT_W-1:0]   free_tot   [NCPU];
    logic [TOT_W-1:0]   borrow_tot [NCPU];
    logic [TOT_W-1:0]   lend_tot   [NCPU];
    logic [SYSO_W-1:0]  sys_free;
    logic [BYTES_W-1:0] size_limit;

    // Replies the block still owes, oldest first.
    pool_reply_t pending_replies[$];
    stim_row_t   directed_rows[$];

    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int status_tally[8];
    int borrow_grants  = 0;
    int unsigned cycle_count = 0;

    per_cpu_block_pool_allocator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("per_cpu_block_pool_allocator_core test failed");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate set by the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic void reset_pool_model();
        for (int p = 0; p < NCPU; p++) begin
            busy_map[p]   = '0;
            free_cnt[p]   = PCNT_W'(NBLK);
            used_cnt[p]   = '0;
            alloc_tot[p]  = '0;
            free_tot[p]   = '0;
            borrow_tot[p] = '0;
            lend_tot[p]   = '0;
        end
        sys_free   = SYSO_W'(NCPU * NBLK);
        size_limit = MAX_BYTES_RST;
    endfunction

    // Only called when the pool has at least one free block.
    function automatic int lowest_free_block(input int p);
        int b;
        b = 0;
        while (busy_map[p][b]) b++;
        return b;
    endfunction

    function automatic void take_block(input int p, input int b);
        busy_map[p][b] = 1'b1;
        free_cnt[p]--;
        used_cnt[p]++;
        sys_free--;
    endfunction

    // Applies one accepted request to the shadow state and returns the reply.
    // The requester and block index fields are too narrow to go out of range with
    // eight pools of 64 blocks, so those rejections cannot be provoked here.
    function automatic void predict_pool_step(input pool_req_t r, output pool_reply_t e);
        int c;
        int b;
        int best;
        logic [PCNT_W-1:0] most;
        bit size_ok;
        c = r.word.cpu;
        size_ok = (r.word.bytes != 0) && (r.word.bytes <= size_limit);
        e = '0;
        e.status = ST_OK;
        if (r.func == FUNC_UNKNOWN) begin
            e.status = ST_BAD_REQ;
        end else if (r.func == FUNC_ALLOC) begin
            if (!size_ok) begin
                e.status = ST_BAD_REQ;
            end else if (free_cnt[c] != 0) begin
                b = lowest_free_block(c);
                take_block(c, b);
                alloc_tot[c]++;
                e.word.gpool  = CPU_F_W'(c);
                e.word.gblock = HBLK_W'(b);
            end else begin
                // Own pool is full: steal from the other pool with strictly the
                // most free blocks, lowest index winning a tie.
                best = -1;
                most = '0;
                for (int p = 0; p < NCPU; p++) begin
                    if (p != c && free_cnt[p] > most) begin
                        most = free_cnt[p];
                        best = p;
                    end
                end
                if (best < 0) begin
                    e.status = ST_NO_BLOCK;
                end else begin
                    b = lowest_free_block(best);
                    take_block(best, b);
                    lend_tot[best]++;
                    borrow_tot[c]++;
                    borrow_grants++;
                    e.word.gpool  = CPU_F_W'(best);
                    e.word.gblock = HBLK_W'(b);
                end
            end
        end else if (r.func == FUNC_FREE) begin
            if (!size_ok) begin
                e.status = ST_BAD_REQ;
            end else if (r.word.hpool != CPU_F_W'(c)) begin
                e.status = ST_NOT_LOCAL;
            end else if (!busy_map[c][r.word.hblock]) begin
                e.status = ST_DOUBLE_FREE;
            end else begin
                busy_map[c][r.word.hblock] = 1'b0;
                free_cnt[c]++;
                used_cnt[c]--;
                free_tot[c]++;
                sys_free++;
            end
        end
        // A statistics request changes nothing and just reports the counters below.
        e.word.pool_free    = free_cnt[c];
        e.word.pool_used    = used_cnt[c];
        e.word.alloc_total  = alloc_tot[c];
        e.word.free_total   = free_tot[c];
        e.word.borrow_total = borrow_tot[c];
        e.word.lend_total   = lend_tot[c];
        e.word.sys_free     = sys_free;
        status_tally[e.status]++;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic pool_req_t make_req(input logic [FUNC_W-1:0] func, input int cpu,
                                           input int bytes, input int hpool, input int hblk);
        pool_req_t r;
        r = '0;
        r.func        = func;
        r.word.cpu    = CPU_F_W'(cpu);
        r.word.bytes  = BYTES_W'(bytes);
        r.word.hpool  = CPU_F_W'(hpool);
        r.word.hblock = HBLK_W'(hblk);
        return r;
    endfunction

    function automatic pool_reply_t make_reply(input logic [STATUS_W-1:0] st, input int gp,
                                               input int gb, input int pf, input int pu,
                                               input int at, input int ft, input int bt,
                                               input int lt, input int sf);
        pool_reply_t e;
        e = '0;
        e.status            = st;
        e.word.gpool        = CPU_F_W'(gp);
        e.word.gblock       = HBLK_W'(gb);
        e.word.pool_free    = PCNT_W'(pf);
        e.word.pool_used    = PCNT_W'(pu);
        e.word.alloc_total  = TOT_W'(at);
        e.word.free_total   = TOT_W'(ft);
        e.word.borrow_total = TOT_W'(bt);
        e.word.lend_total   = TOT_W'(lt);
        e.word.sys_free     = SYSO_W'(sf);
        return e;
    endfunction

    function automatic void add_row(input pool_req_t q, input bit typed, input pool_reply_t rep);
        stim_row_t row;
        row.is_cfg    = 1'b0;
        row.cfg_value = '0;
        row.req       = q;
        row.typed     = typed;
        row.reply     = rep;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input logic [BYTES_W-1:0] v);
        stim_row_t row;
        row.is_cfg    = 1'b1;
        row.cfg_value = v;
        row.req       = '0;
        row.typed     = 1'b0;
        row.reply     = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [BYTES_W-1:0] legal_size();
        return BYTES_W'($urandom_range(int'(size_limit), 1));
    endfunction

    function automatic logic [BYTES_W-1:0] illegal_size();
        if (size_limit == '1 || $urandom_range(1) == 0) return '0;
        return BYTES_W'($urandom_range(65535, int'(size_limit) + 1));
    endfunction

    // Builds one random request. Most are well formed: allocations skewed toward
    // pools 0 and 1 so that they fill and start stealing, and frees aimed at blocks
    // the shadow map knows to be busy. The rest is noise and malformed requests.
    function automatic pool_req_t random_request(input int alloc_pct, input int free_pct);
        pool_req_t r;
        int c;
        int b;
        int pick;
        r = '0;
        r.func        = FUNC_ALLOC;
        r.word.cpu    = CPU_F_W'($urandom_range(NCPU - 1));
        r.word.bytes  = legal_size();
        r.word.hpool  = CPU_F_W'($urandom_range(NCPU - 1));
        r.word.hblock = HBLK_W'($urandom_range(NBLK - 1));
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
            if ($urandom_range(1) == 1) r.word.cpu = CPU_F_W'($urandom_range(1));
        end else if (pick < alloc_pct + free_pct) begin
            // Find a pool with something to give back, starting at a random one.
            c = r.word.cpu;
            for (int k = 0; k < NCPU && used_cnt[c] == 0; k++) c = (c + 1) % NCPU;
            r.func       = FUNC_FREE;
            r.word.cpu   = CPU_F_W'(c);
            r.word.hpool = CPU_F_W'(c);
            if (used_cnt[c] != 0) begin
                b = $urandom_range(NBLK - 1);
                while (!busy_map[c][b]) b = (b + 1) % NBLK;
                r.word.hblock = HBLK_W'(b);
            end
        end else begin
            c = r.word.cpu;
            case ($urandom_range(4))
                0: begin
                    r.func       = ($urandom_range(1) == 1) ? FUNC_FREE : FUNC_ALLOC;
                    r.word.bytes = illegal_size();
                end
                1: begin
                    // Return a block that belongs to some other pool.
                    r.func       = FUNC_FREE;
                    r.word.hpool = CPU_F_W'(c + $urandom_range(NCPU - 1, 1));
                end
                2: begin
                    // Free a block of the own pool that is most likely not busy.
                    r.func       = FUNC_FREE;
                    r.word.hpool = CPU_F_W'(c);
                    if (free_cnt[c] != 0) begin
                        b = $urandom_range(NBLK - 1);
                        while (busy_map[c][b]) b = (b + 1) % NBLK;
                        r.word.hblock = HBLK_W'(b);
                    end
                end
                3: begin
                    r.func       = FUNC_STATS;
                    r.word.bytes = BYTES_W'($urandom_range(65535));
                end
                default: begin
                    r.func       = FUNC_UNKNOWN;
                    r.word.bytes = BYTES_W'($urandom_range(65535));
                end
            endcase
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Presents one request after an optional random gap and waits until it is
    // accepted; the expectation is queued at the accepting edge. A typed reply
    // from the directed list replaces the predicted one, the shadow state is
    // updated either way.
    task automatic send_request(input pool_req_t r, input bit typed, input pool_reply_t hand_reply);
        pool_reply_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= r.word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pool_step(r, predicted);
        pending_replies.push_back(typed ? hand_reply : predicted);
    endtask

    // Holds the request channel quiet until every owed reply has come back.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    // Every request yields a reply and the state settles with that reply, so once
    // the queue is empty the block is idle and the size limit may change.
    task automatic write_size_limit(input logic [BYTES_W-1:0] v);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        size_limit = v;
    endtask

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Values are read as they stood just before the edge, so a reply counts as
    // delivered exactly at the edge where m_tvalid and m_tready were both high.
    always @(posedge aclk) begin
        pool_reply_t want;
        pool_reply_t got;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("reply with status %0d arrived with no request outstanding", m_tuser);
                error_count++;
            end else begin
                want        = pending_replies.pop_front();
                got.status  = m_tuser;
                got.word    = m_tdata;
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("granted_pool", 32'(want.word.gpool), 32'(got.word.gpool));
                check_field("granted_block", 32'(want.word.gblock), 32'(got.word.gblock));
                check_field("pool_free_blocks", 32'(want.word.pool_free),
                            32'(got.word.pool_free));
                check_field("pool_used_blocks", 32'(want.word.pool_used),
                            32'(got.word.pool_used));
                check_field("pool_alloc_total", want.word.alloc_total, got.word.alloc_total);
                check_field("pool_free_total", want.word.free_total, got.word.free_total);
                check_field("pool_borrow_total", want.word.borrow_total,
                            got.word.borrow_total);
                check_field("pool_lend_total", want.word.lend_total, got.word.lend_total);
                check_field("system_free_blocks", 32'(want.word.sys_free),
                            32'(got.word.sys_free));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------

    initial begin
        int phase_limit [4];
        int phase_send  [4];
        int phase_recv  [4];
        int phase_alloc [4];
        int phase_free  [4];
        int total;

        // Directed list. It opens on the state straight out of reset with the
        // default 256-byte limit, then walks the size bounds, the malformed, foreign and
        // double free rejections and both limit extremes.
        add_row(make_req(FUNC_STATS, 0, 0, 7, 63), 1'b1,
                make_reply(ST_OK, 0, 0, 64, 0, 0, 0, 0, 0, 512));
        add_row(make_req(FUNC_ALLOC, 0, 1, 0, 0), 1'b1,
                make_reply(ST_OK, 0, 0, 63, 1, 1, 0, 0, 0, 511));
        add_row(make_req(FUNC_ALLOC, 7, 256, 5, 33), 1'b1,
                make_reply(ST_OK, 7, 0, 63, 1, 1, 0, 0, 0, 510));
        // One byte over the limit, and a zero size.
        add_row(make_req(FUNC_ALLOC, 3, 257, 0, 0), 1'b1,
                make_reply(ST_BAD_REQ, 0, 0, 64, 0, 0, 0, 0, 0, 510));
        add_row(make_req(FUNC_ALLOC, 3, 0, 0, 0), 1'b1,
                make_reply(ST_BAD_REQ, 0, 0, 64, 0, 0, 0, 0, 0, 510));
        add_row(make_req(FUNC_FREE, 0, 0, 0, 0), 1'b1,
                make_reply(ST_BAD_REQ, 0, 0, 63, 1, 1, 0, 0, 0, 510));
        // A block of pool 7 handed back by CPU 0.
        add_row(make_req(FUNC_FREE, 0, 256, 7, 0), 1'b1,
                make_reply(ST_NOT_LOCAL, 0, 0, 63, 1, 1, 0, 0, 0, 510));
        // Block 1 of pool 0 was never taken.
        add_row(make_req(FUNC_FREE, 0, 16, 0, 1), 1'b1,
                make_reply(ST_DOUBLE_FREE, 0, 0, 63, 1, 1, 0, 0, 0, 510));
        add_row(make_req(FUNC_FREE, 0, 16, 0, 0), 1'b1,
                make_reply(ST_OK, 0, 0, 64, 0, 1, 1, 0, 0, 511));
        add_row(make_req(FUNC_UNKNOWN, 5, 100, 5, 0), 1'b1,
                make_reply(ST_BAD_REQ, 0, 0, 64, 0, 0, 0, 0, 0, 511));
        add_row(make_req(FUNC_FREE, 7, 65535, 7, 63), 1'b1,
                make_reply(ST_BAD_REQ, 0, 0, 63, 1, 1, 0, 0, 0, 511));
        // With the widest limit the largest size is legal.
        add_cfg_row(16'hFFFF);
        add_row(make_req(FUNC_FREE, 7, 65535, 7, 63), 1'b1,
                make_reply(ST_DOUBLE_FREE, 0, 0, 63, 1, 1, 0, 0, 0, 511));
        add_row(make_req(FUNC_FREE, 7, 65535, 7, 0), 1'b1,
                make_reply(ST_OK, 0, 0, 64, 0, 1, 1, 0, 0, 512));
        // Statistics ignore the size, even zero.
        add_row(make_req(FUNC_STATS, 2, 0, 7, 63), 1'b1,
                make_reply(ST_OK, 0, 0, 64, 0, 0, 0, 0, 0, 512));
        // Narrowest limit: only one byte passes.
        add_cfg_row(16'd1);
        add_row(make_req(FUNC_ALLOC, 6, 2, 0, 0), 1'b1,
                make_reply(ST_BAD_REQ, 0, 0, 64, 0, 0, 0, 0, 0, 512));
        add_row(make_req(FUNC_ALLOC, 6, 1, 7, 63), 1'b1,
                make_reply(ST_OK, 6, 0, 63, 1, 1, 0, 0, 0, 511));
        add_row(make_req(FUNC_ALLOC, 6, 1, 3, 17), 1'b0, '0);
        add_row(make_req(FUNC_UNKNOWN, 7, 0, 2, 9), 1'b0, '0);
        add_row(make_req(FUNC_STATS, 6, 40000, 4, 42), 1'b0, '0);

        // Random phases. The first two lean on allocation until every pool is full
        // and allocations start failing, the last two drain the pools again.
        phase_limit = '{65535, $urandom_range(65534, 2), 1, $urandom_range(1024, 1)};
        phase_send  = '{0, 47, 0, 17};
        phase_recv  = '{0, 0, 47, 17};
        phase_alloc = '{85, 85, 25, 25};
        phase_free  = '{5, 5, 60, 60};

        foreach (status_tally[i]) status_tally[i] = 0;
        reset_pool_model();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                write_size_limit(directed_rows[i].cfg_value);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].reply);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            write_size_limit(BYTES_W'(phase_limit[ph]));
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Halfway through each phase the sender waits for every reply.
                if (n == PHASE_ITEMS / 2) drain_replies();
                send_request(random_request(phase_alloc[ph], phase_free[ph]), 1'b0, '0);
            end
        end

        drain_replies();
        repeat (8) @(posedge aclk);

        total = 0;
        foreach (status_tally[i]) total += status_tally[i];
        $display("Covered %0d requests, four idle patterns, limits 1..65535: %0d ok, %0d stolen.",
                 total, status_tally[ST_OK], borrow_grants);
        $display("Rejected: %0d malformed, %0d no block, %0d foreign frees, %0d double frees.",
                 status_tally[ST_BAD_REQ], status_tally[ST_NO_BLOCK],
                 status_tally[ST_NOT_LOCAL], status_tally[ST_DOUBLE_FREE]);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("per_cpu_block_pool_allocator_core test passed");
        end else begin
            $display("per_cpu_block_pool_allocator_core test failed");
        end
        $finish;
    end

endmodule
